@@ rtl/core/sacl_pkg.sv @@
// shared constants and types for the lru-stamp cache tag model
package sacl_pkg;

    localparam int SETS      = 512;
    localparam int WAYS      = 8;
    localparam int LINE_SIZE = 64;

    localparam int OFF_BITS  = $clog2(LINE_SIZE);
    localparam int IDX_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int IDX_USED  = $clog2(SETS);
    localparam int TAG_BITS  = 32 - OFF_BITS - IDX_USED;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LINE_BITS = TAG_BITS + 2 + 32;

    typedef logic [IDX_BITS-1:0]  set_t;
    typedef logic [TAG_BITS-1:0]  tag_t;
    typedef logic [WAY_BITS-1:0]  way_t;

    typedef struct packed {
        tag_t        tag;
        logic        valid;
        logic        dirty;
        logic [31:0] stamp;
    } line_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic clear;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
    } stat_t;

endpackage

@@ rtl/core/sacl_ctrl.sv @@
// controller: clear pass, idle and lookup states
module sacl_ctrl
    import sacl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  busy
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear = 1'b1;
                if (stat.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                ctrl.lookup = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/core/sacl_dp.sv @@
// datapath: set memory, hit and victim search, counters
module sacl_dp
    import sacl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    input  logic [31:0] addr,
    input  logic        wr_en,
    output stat_t       stat,
    output logic        done,
    output logic        hit,
    output logic        dirty_eviction,
    output logic [31:0] hits_total,
    output logic [31:0] misses_total,
    output logic [31:0] evictions_total
);

    // one row per set, all ways side by side
    logic [WAYS*LINE_BITS-1:0] mem [SETS];
    logic [WAYS*LINE_BITS-1:0] rd_reg;

    set_t        set_reg;
    tag_t        tag_reg;
    logic        wr_reg;
    logic [31:0] stamp_reg, hits_reg, misses_reg, evict_reg;
    set_t        clr_reg;
    logic        done_reg, hit_reg, dev_reg;

    set_t set_in;
    tag_t tag_in;
    assign set_in = IDX_BITS'((addr >> OFF_BITS) & 32'(SETS - 1));
    assign tag_in = TAG_BITS'(addr >> (OFF_BITS + IDX_USED));

    // hit search and victim choice over the row
    line_t lines [WAYS];
    logic  found;
    way_t  hway, vway;
    logic [31:0] vmin;
    logic [31:0] stamp_new;
    line_t newl;
    logic [WAYS*LINE_BITS-1:0] wrow;

    always_comb
    begin
        found = 1'b0;
        hway  = '0;
        vway  = '0;
        for (int w = 0; w < WAYS; w++)
            lines[w] = line_t'(rd_reg[w*LINE_BITS +: LINE_BITS]);
        vmin = lines[0].stamp;
        for (int w = WAYS - 1; w >= 0; w--)
            if (lines[w].valid && lines[w].tag == tag_reg)
            begin
                found = 1'b1;
                hway  = way_t'(w);
            end
        for (int w = 1; w < WAYS; w++)
            if (lines[w].stamp < vmin)
            begin
                vmin = lines[w].stamp;
                vway = way_t'(w);
            end
        stamp_new = stamp_reg + 32'd1;
        if (found)
        begin
            newl       = lines[hway];
            newl.dirty = lines[hway].dirty | wr_reg;
            newl.stamp = stamp_new;
        end
        else
        begin
            newl.tag   = tag_reg;
            newl.valid = 1'b1;
            newl.dirty = wr_reg;
            newl.stamp = stamp_new;
        end
        wrow = rd_reg;
        wrow[(found ? hway : vway)*LINE_BITS +: LINE_BITS] = newl;
    end

    // memory: clear sweep, row read, row write-back
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
            mem[clr_reg] <= '0;
        else if (ctrl.lookup)
            mem[set_reg] <= wrow;
        if (ctrl.load)
            rd_reg <= mem[set_in];
    end

    // access payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
            wr_reg  <= wr_en;
        end
    end

    // counters, stamp, clear pointer, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evict_reg  <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
            dev_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.lookup;
            if (ctrl.clear)
                clr_reg <= clr_reg + set_t'(1);
            if (ctrl.lookup)
            begin
                stamp_reg <= stamp_new;
                hit_reg   <= found;
                dev_reg   <= !found && lines[vway].dirty;
                if (found)
                    hits_reg <= hits_reg + 32'd1;
                else
                begin
                    misses_reg <= misses_reg + 32'd1;
                    if (lines[vway].dirty)
                        evict_reg <= evict_reg + 32'd1;
                end
            end
        end
    end

    assign stat.clear_done = (32'(clr_reg) == 32'(SETS - 1));
    assign done            = done_reg;
    assign hit             = hit_reg;
    assign dirty_eviction  = dev_reg;
    assign hits_total      = hits_reg;
    assign misses_total    = misses_reg;
    assign evictions_total = evict_reg;

endmodule

@@ rtl/core/set_assoc_cache_lru_stamp_top.sv @@
// top level of the lru-stamp set-associative cache tag model
//
//  channel  | handshake      | payload
//  ---------+----------------+----------------------------------------------
//  access   | start / busy   | addr, wr_en
//  result   | done (strobe)  | hit, dirty_eviction, hits/misses/evictions_total
//
// the accepting edge reads the set row for an item, and the next edge compares,
// writes the row back and registers the result, which then shows on done; a new
// item is taken only once the last one has written its row back (set memory port)
// after reset a clearing pass zeroes all SETS (512) rows of the set memory, busy high
// results show for one cycle on done; the receiver cannot stall
module set_assoc_cache_lru_stamp_top
    import sacl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] addr,
    input  logic        wr_en,
    output logic        done,
    output logic        hit,
    output logic        dirty_eviction,
    output logic [31:0] hits_total,
    output logic [31:0] misses_total,
    output logic [31:0] evictions_total
);

    ctrl_t ctrl;
    stat_t stat;

    sacl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    sacl_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .addr            (addr),
        .wr_en           (wr_en),
        .stat            (stat),
        .done            (done),
        .hit             (hit),
        .dirty_eviction  (dirty_eviction),
        .hits_total      (hits_total),
        .misses_total    (misses_total),
        .evictions_total (evictions_total)
    );

endmodule

@@ rtl/core/sacl_checker.sv @@
// port-level checker for the cache tag model, bound to the top level
module sacl_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        dirty_eviction,
    input logic [31:0] hits_total,
    input logic [31:0] misses_total,
    input logic [31:0] evictions_total
);

    // an accepted item makes the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // a result shows on done after the lookup state that follows accept
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("result missing");

    // a hit never reports a dirty eviction
    a_hitev: assert property (@(posedge clk) disable iff (!rst_n)
        done && hit |-> !dirty_eviction)
        else $error("dirty eviction on hit");

    // a fresh hit result leaves the miss counter unchanged
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) == 1'b0 && hit |-> $stable(misses_total))
        else $error("miss count moved on hit");

endmodule

bind set_assoc_cache_lru_stamp_top sacl_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .hit             (hit),
    .dirty_eviction  (dirty_eviction),
    .hits_total      (hits_total),
    .misses_total    (misses_total),
    .evictions_total (evictions_total)
);
